FILE: hw/rtl/b64_pkg.sv
// Shared types, constants and alphabet functions for the base64url stream codec.
`timescale 1ns / 1ps

package b64_pkg;

  // Depth of the command queue between the front and the back.
  localparam int unsigned CMD_DEPTH = 4;

  // Alphabet anchor codes.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_UNDER   = 8'h5F;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  // One command: the results caused by one input item.
  typedef struct packed {
    logic [3:0][7:0] chars;    // result bytes, element 0 first
    logic [1:0]      cnt_m1;   // number of results minus one
    logic            valid;    // results carry data
    logic            last;     // final result carries the stream end
    logic            stopped;  // decoder halt status
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] r;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      r = CHAR_UPPER_A + v8;
    end else if (v < 6'd52) begin
      r = CHAR_LOWER_A + v8 - 8'd26;
    end else if (v < 6'd62) begin
      r = CHAR_DIGIT_0 + v8 - 8'd52;
    end else if (v == 6'd62) begin
      r = CHAR_MINUS;
    end else begin
      r = CHAR_UNDER;
    end
    return r;
  endfunction

  function automatic sextet_t dec_sextet(input logic [7:0] c);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      s.val = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      s.val = 6'(c - CHAR_LOWER_A + 8'd26);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      s.val = 6'(c - CHAR_DIGIT_0 + 8'd52);
    end else if (c == CHAR_MINUS) begin
      s.val = 6'd62;
    end else if (c == CHAR_UNDER) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

FILE: hw/rtl/b64_front.sv
// Front end: takes input items, keeps the encode and decode stream state, builds commands.
`timescale 1ns / 1ps

module b64_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  b64_pkg::mode_e       mode_i,
  output logic                 cmd_push_o,
  output b64_pkg::cmd_t        cmd_o
);

  logic [1:0]  group_q, group_d;
  logic [15:0] held_q, held_d;
  logic [11:0] acc_q, acc_d;
  logic [1:0]  phase_q, phase_d;
  logic        halted_q, halted_d;

  logic [7:0]       b0, b1, b2;
  logic             enc_emit;
  b64_pkg::sextet_t sx;
  logic [11:0]      acc_new;
  logic [7:0]       dec_byte;

  always_comb begin
    b0 = in_byte_i;
    b1 = '0;
    b2 = '0;
    unique case (group_q)
      2'd0: begin
        b0 = in_byte_i;
      end
      2'd1: begin
        b0 = held_q[15:8];
        b1 = in_byte_i;
      end
      default: begin
        b0 = held_q[15:8];
        b1 = held_q[7:0];
        b2 = in_byte_i;
      end
    endcase
    enc_emit = group_q[1] | in_last_i;

    sx      = b64_pkg::dec_sextet(in_byte_i);
    acc_new = {acc_q[5:0], sx.val};
    unique case (phase_q)
      2'd1:    dec_byte = acc_new[7:0];
      2'd2:    dec_byte = acc_new[9:2];
      default: dec_byte = acc_new[11:4];
    endcase
  end

  always_comb begin
    group_d  = group_q;
    held_d   = held_q;
    acc_d    = acc_q;
    phase_d  = phase_q;
    halted_d = halted_q;

    cmd_push_o    = 1'b0;
    cmd_o.chars   = '0;
    cmd_o.cnt_m1  = '0;
    cmd_o.valid   = 1'b1;
    cmd_o.last    = in_last_i;
    cmd_o.stopped = 1'b0;

    if (fire_i) begin
      if (mode_i == b64_pkg::MODE_ENCODE) begin
        cmd_o.chars[0] = b64_pkg::enc_char(b0[7:2]);
        cmd_o.chars[1] = b64_pkg::enc_char({b0[1:0], b1[7:4]});
        cmd_o.chars[2] = b64_pkg::enc_char({b1[3:0], b2[7:6]});
        cmd_o.chars[3] = b64_pkg::enc_char(b2[5:0]);
        cmd_o.cnt_m1   = group_q[1] ? 2'd3 : (group_q + 2'd1);
        if (enc_emit) begin
          cmd_push_o = 1'b1;
          group_d    = '0;
          held_d     = '0;
        end else if (group_q == 2'd0) begin
          held_d  = {in_byte_i, 8'h00};
          group_d = 2'd1;
        end else begin
          held_d  = {held_q[15:8], in_byte_i};
          group_d = 2'd2;
        end
      end else begin
        if (!halted_q) begin
          if (!sx.ok) begin
            halted_d = 1'b1;
          end else begin
            acc_d = acc_new;
            if (phase_q == 2'd0) begin
              phase_d = 2'd3;
            end else begin
              cmd_push_o     = 1'b1;
              cmd_o.chars[0] = dec_byte;
              phase_d        = phase_q - 2'd1;
            end
          end
        end
        // A stream end that yields no byte still leaves a bare end marker.
        if (in_last_i && !cmd_push_o) begin
          cmd_push_o    = 1'b1;
          cmd_o.valid   = 1'b0;
          cmd_o.stopped = halted_d;
        end
      end
      if (in_last_i) begin
        group_d  = '0;
        held_d   = '0;
        acc_d    = '0;
        phase_d  = '0;
        halted_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q  <= '0;
      held_q   <= '0;
      acc_q    <= '0;
      phase_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      group_q  <= group_d;
      held_q   <= held_d;
      acc_q    <= acc_d;
      phase_q  <= phase_d;
      halted_q <= halted_d;
    end
  end

  a_group_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_q != 2'd3)
    else $error("encode group position reached three");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && in_last_i) |=> (group_q == 2'd0 && phase_q == 2'd0 && !halted_q))
    else $error("stream end did not clear the stream state");

endmodule

FILE: hw/rtl/b64_fifo.sv
// Command queue between the front end and the back end.
`timescale 1ns / 1ps

module b64_fifo #(
  parameter int unsigned Depth = b64_pkg::CMD_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  b64_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output b64_pkg::cmd_t rd_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  b64_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_wr, do_rd;

  assign full_o    = (count_q == CW'(Depth));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("command queue count beyond depth");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("empty command queue with unequal pointers");

endmodule

FILE: hw/rtl/b64_back.sv
// Back end: walks each command and presents one result per transaction.
`timescale 1ns / 1ps

module b64_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  b64_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    out_byte_o,
  output logic          out_valid_o,
  output logic          out_last_o,
  output logic          stopped_o
);

  b64_pkg::cmd_t cur_q, cur_d;
  logic          cur_vld_q, cur_vld_d;
  logic [1:0]    idx_q, idx_d;
  logic          res_full_q, res_full_d;
  logic [7:0]    res_byte_q, res_byte_d;
  logic          res_valid_q, res_valid_d;
  logic          res_last_q, res_last_d;
  logic          res_stop_q, res_stop_d;
  logic          res_ld, at_end, fin;

  assign empty_o     = !res_full_q;
  assign out_byte_o  = res_byte_q;
  assign out_valid_o = res_valid_q;
  assign out_last_o  = res_last_q;
  assign stopped_o   = res_stop_q;

  // The result register reloads whenever it is free or being drained.
  assign res_ld     = !res_full_q || pop_i;
  assign at_end     = (idx_q == cur_q.cnt_m1);
  assign fin        = res_ld && cur_vld_q && at_end;
  assign cmd_take_o = cmd_valid_i && (!cur_vld_q || fin);

  always_comb begin
    res_full_d  = res_full_q;
    res_byte_d  = res_byte_q;
    res_valid_d = res_valid_q;
    res_last_d  = res_last_q;
    res_stop_d  = res_stop_q;
    cur_d       = cur_q;
    cur_vld_d   = cur_vld_q;
    idx_d       = idx_q;

    if (res_ld) begin
      res_full_d = cur_vld_q;
      if (cur_vld_q) begin
        res_byte_d  = cur_q.chars[idx_q];
        res_valid_d = cur_q.valid;
        res_last_d  = cur_q.last && at_end;
        res_stop_d  = cur_q.stopped;
        idx_d       = idx_q + 2'd1;
      end
    end
    if (cmd_take_o) begin
      cur_d     = cmd_i;
      cur_vld_d = 1'b1;
      idx_d     = '0;
    end else if (fin) begin
      cur_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    res_byte_q  <= res_byte_d;
    res_valid_q <= res_valid_d;
    res_last_q  <= res_last_d;
    res_stop_q  <= res_stop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q  <= 1'b0;
      idx_q      <= '0;
      res_full_q <= 1'b0;
    end else begin
      cur_vld_q  <= cur_vld_d;
      idx_q      <= idx_d;
      res_full_q <= res_full_d;
    end
  end

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (idx_q <= cur_q.cnt_m1))
    else $error("result index ran past the command");

endmodule

FILE: hw/rtl/base64url_stream_codec.sv
// Path: an input's command goes into the command queue, then into the back end's current command,
// then into the result register. Throughput: one input per cycle is taken while the command queue
// has room; results leave at one per cycle while pop is asserted, so encode is set by the result port.
// Reset: rst_ni is asynchronous and active low; it clears the mode register, the stream
// state, the command queue and the result register at once, with no clearing pass.
`timescale 1ns / 1ps

module base64url_stream_codec #(
  parameter int unsigned CmdDepth = b64_pkg::CMD_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       out_last_o,
  output logic       stopped_o
);

  b64_pkg::mode_e mode_q, mode_d;
  logic           fire;
  logic           cmd_push;
  b64_pkg::cmd_t  cmd_wr;
  logic           cmd_valid;
  b64_pkg::cmd_t  cmd_head;
  logic           cmd_take;

  assign cfg_ready_o = 1'b1;
  assign mode_d      = (cfg_valid_i) ? b64_pkg::mode_e'(cfg_data_i) : mode_q;
  assign fire        = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= b64_pkg::MODE_ENCODE;
    end else begin
      mode_q <= mode_d;
    end
  end

  b64_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .mode_i     (mode_q),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  b64_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_push),
    .wr_data_i (cmd_wr),
    .full_o    (full),
    .rd_i      (cmd_take),
    .valid_o   (cmd_valid),
    .rd_data_o (cmd_head)
  );

  b64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_take_o  (cmd_take),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .out_last_o  (out_last_o),
    .stopped_o   (stopped_o)
  );

endmodule
